[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/isr_pkg.sv]
// ----------------------------------------------------------------------------
// isr_pkg
// Field widths and fixed pipeline constants of the integer square root.
// ----------------------------------------------------------------------------
package isr_pkg;

	localparam int RADICAND_FIELD_BITS = 32;
	localparam int ROOT_FIELD_BITS     = 16;
	localparam int STEPS_PER_STAGE     = 4;

	typedef logic [RADICAND_FIELD_BITS-1:0] radicand_t;
	typedef logic [ROOT_FIELD_BITS-1:0]     root_t;

endpackage

[rtl/isr_if.sv]
// ----------------------------------------------------------------------------
// isr_arg_if / isr_res_if
// Valid/ready channels carrying one radicand or one root per transaction.
// ----------------------------------------------------------------------------
interface isr_arg_if;
	import isr_pkg::*;

	logic      valid;
	logic      ready;
	radicand_t radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

interface isr_res_if;
	import isr_pkg::*;

	logic  valid;
	logic  ready;
	root_t root;

	modport source (output valid, output root, input ready);
	modport sink   (input valid, input root, output ready);
endinterface

[rtl/isr_stage.sv]
// ----------------------------------------------------------------------------
// isr_stage
// One pipeline stage: a fixed number of two-bit restoring root steps,
// followed by the stage register with its valid bit and stall control.
// ----------------------------------------------------------------------------
module isr_stage #(
	parameter int ROOT_W = 16,
	parameter int STEPS  = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ROOT_W+1:0]   rem_in,
	input  logic [ROOT_W-1:0]   root_in,
	input  logic [2*ROOT_W-1:0] rad_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ROOT_W+1:0]   rem_out,
	output logic [ROOT_W-1:0]   root_out,
	output logic [2*ROOT_W-1:0] rad_out
);
	import isr_pkg::*;

	localparam int REM_W = ROOT_W + 2;
	localparam int RAD_W = 2 * ROOT_W;

	logic              valid_s;
	logic [REM_W-1:0]  rem_s;
	logic [ROOT_W-1:0] root_s;
	logic [RAD_W-1:0]  rad_s;

	logic [REM_W-1:0]  rem_nxt;
	logic [ROOT_W-1:0] root_nxt;
	logic [RAD_W-1:0]  rad_nxt;
	logic              load;

	assign in_ready = !valid_s || out_ready;
	assign load     = in_valid && in_ready;

	always_comb begin
		logic [REM_W-1:0] trial;
		rem_nxt  = rem_in;
		root_nxt = root_in;
		rad_nxt  = rad_in;
		trial    = '0;
		for (int k = 0; k < STEPS; k++) begin
			rem_nxt = {rem_nxt[REM_W-3:0], rad_nxt[RAD_W-1 -: 2]};
			rad_nxt = {rad_nxt[RAD_W-3:0], 2'b00};
			trial   = {root_nxt, 2'b01};
			if (rem_nxt >= trial) begin
				rem_nxt  = rem_nxt - trial;
				root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
			end else begin
				root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_s  <= rem_nxt;
			root_s <= root_nxt;
			rad_s  <= rad_nxt;
		end
	end

	assign out_valid = valid_s;
	assign rem_out   = rem_s;
	assign root_out  = root_s;
	assign rad_out   = rad_s;

endmodule

[rtl/integer_square_root.sv]
// ----------------------------------------------------------------------------
// integer_square_root
// Floor square root of an unsigned radicand, digit by digit, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   arg  - sink channel; one radicand per transaction. Bits above
//          RADICAND_BITS are ignored.
//   res  - source channel; one root per transaction, in arrival order,
//          the largest value whose square does not exceed the radicand.
//   Each stage resolves four root bits with a chain of four two-bit
//   subtract-and-compare steps; (RADICAND_BITS+1)/2 bits need
//   ceil(steps/4) stages, which is four stages at the default width.
//   Each radicand is registered once per stage, in stage order.
//   Throughput: one transaction per cycle while res is taken.
//   Stall: a stage holds while the next one is full and not draining;
//   arg.ready drops only when every stage holds a transaction.
//   Reset: all stage valid bits clear; nothing is kept between items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_square_root #(
	parameter int RADICAND_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	isr_arg_if.sink   arg,
	isr_res_if.source res
);
	import isr_pkg::*;

	localparam int STEPS      = (RADICAND_BITS + 1) / 2;
	localparam int NUM_STAGES = (STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int ROOT_W     = NUM_STAGES * STEPS_PER_STAGE;
	localparam int REM_W      = ROOT_W + 2;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int KEEP_BITS  = (RADICAND_BITS < RADICAND_FIELD_BITS) ?
		RADICAND_BITS : RADICAND_FIELD_BITS;

	logic              valid_c [NUM_STAGES+1];
	logic              ready_c [NUM_STAGES+1];
	logic [REM_W-1:0]  rem_c   [NUM_STAGES+1];
	logic [ROOT_W-1:0] root_c  [NUM_STAGES+1];
	logic [RAD_W-1:0]  rad_c   [NUM_STAGES+1];
	logic [NUM_STAGES-1:0] busy;

	assign valid_c[0] = arg.valid;
	assign arg.ready  = ready_c[0];
	assign rem_c[0]   = '0;
	assign root_c[0]  = '0;
	assign rad_c[0]   = RAD_W'(arg.radicand[KEEP_BITS-1:0]);

	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
		isr_stage #(
			.ROOT_W (ROOT_W),
			.STEPS  (STEPS_PER_STAGE)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[g]),
			.in_ready  (ready_c[g]),
			.rem_in    (rem_c[g]),
			.root_in   (root_c[g]),
			.rad_in    (rad_c[g]),
			.out_valid (valid_c[g+1]),
			.out_ready (ready_c[g+1]),
			.rem_out   (rem_c[g+1]),
			.root_out  (root_c[g+1]),
			.rad_out   (rad_c[g+1])
		);
		assign busy[g] = valid_c[g+1];
	end

	assign res.valid          = valid_c[NUM_STAGES];
	assign ready_c[NUM_STAGES] = res.ready;

	if (ROOT_W >= ROOT_FIELD_BITS) begin : g_root_trunc
		assign res.root = root_c[NUM_STAGES][ROOT_FIELD_BITS-1:0];
	end else begin : g_root_ext
		assign res.root = ROOT_FIELD_BITS'(root_c[NUM_STAGES]);
	end

	`ASSERT_SAME(a_full_when_blocked, !arg.ready, $countones(busy) == NUM_STAGES)
	`ASSERT_NEXT(a_accept_fills_first, arg.valid && arg.ready, valid_c[1])
	`ASSERT_SAME(a_drop_only_on_take, $fell(res.valid), $past(res.ready))

endmodule

[sim/tb_integer_square_root.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_square_root
// Self-checking bench for the digit-by-digit floor square root. A queue of
// radicands (edge values, perfect squares and their neighbors, narrow and
// full-width random values) is sent in bursts. The sink side stalls on a
// changing pattern. Every root is compared against a local floor-sqrt
// predictor in arrival order.
// ----------------------------------------------------------------------------
module tb_integer_square_root;
	import isr_pkg::*;

	localparam int RADICAND_BITS = 32;
	localparam int ROOT_STEPS    = (RADICAND_BITS + 1) / 2;
	localparam int RANDOM_ITEMS  = 1750;
	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		radicand_t radicand;
		bit        drain_first;
	} pending_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_MOSTLY,
		READY_BURSTY
	} ready_mode_t;

	logic clk;
	logic arst_n;

	isr_arg_if arg_if ();
	isr_res_if res_if ();

	integer_square_root #(
		.RADICAND_BITS(RADICAND_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.arg(arg_if),
		.res(res_if)
	);

	pending_t    pending_radicands[$];
	root_t       expected_roots[$];
	root_t       want_root;
	int          outstanding;
	int          sent_count;
	int          checked_count;
	int          error_count;
	int          total_items;
	int          burst_left;
	int          gap_left;
	int          idle_cycles;
	ready_mode_t ready_mode;
	int          mode_left;
	int          hold_left;

	function automatic root_t floor_sqrt(radicand_t value);
		logic [63:0] masked;
		logic [63:0] partial;
		logic [63:0] trial;
		masked  = (RADICAND_BITS >= 64) ? {32'd0, value}
			: ({32'd0, value} & ((64'd1 << RADICAND_BITS) - 64'd1));
		partial = 64'd0;
		for (int k = ROOT_STEPS - 1; k >= 0; k--) begin
			trial = {partial[62:0], 1'b1};
			if (trial * trial <= (masked >> (2 * k)))
				partial = trial;
			else
				partial = {partial[62:0], 1'b0};
		end
		return partial[ROOT_FIELD_BITS-1:0];
	endfunction

	function automatic radicand_t random_radicand();
		logic [31:0] r;
		int          pick;
		pick = $urandom_range(0, 99);
		r    = $urandom_range(0, 65535);
		if (pick < 40)
			return $urandom;
		else if (pick < 65) begin
			case ($urandom_range(0, 3))
				0: return r * r - 32'd1;
				1: return r * r;
				2: return r * r + 32'd1;
				default: return r * r + 2 * r;
			endcase
		end else if (pick < 85)
			return $urandom >> $urandom_range(0, 31);
		else
			return 32'hFFFE0001 + $urandom_range(0, 32'h1FFFE);
	endfunction

	task automatic queue_radicand(radicand_t value, bit drain_first);
		pending_t item;
		item.radicand    = value;
		item.drain_first = drain_first;
		pending_radicands.push_back(item);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// sender: bursts of random length, random gaps, hold while not taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_if.valid    <= 1'b0;
			arg_if.radicand <= '0;
			burst_left      <= 0;
			gap_left        <= 0;
		end else if (!arg_if.valid || arg_if.ready) begin
			if (gap_left != 0) begin
				arg_if.valid <= 1'b0;
				gap_left     <= gap_left - 1;
			end else if (pending_radicands.size() != 0 &&
				!(pending_radicands[0].drain_first && (outstanding != 0 || arg_if.valid))) begin
				arg_if.valid    <= 1'b1;
				arg_if.radicand <= pending_radicands[0].radicand;
				void'(pending_radicands.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				arg_if.valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches between modes at random intervals
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			ready_mode   <= READY_ALWAYS;
			mode_left    <= 0;
			hold_left    <= 0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= ready_mode_t'($urandom_range(0, 3));
				mode_left  <= $urandom_range(50, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				READY_ALWAYS: res_if.ready <= 1'b1;
				READY_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
				READY_MOSTLY: res_if.ready <= ($urandom_range(0, 7) != 0);
				default: begin
					if (hold_left != 0) begin
						res_if.ready <= 1'b0;
						hold_left    <= hold_left - 1;
					end else begin
						res_if.ready <= 1'b1;
						hold_left    <= ($urandom_range(0, 5) == 0) ? $urandom_range(4, 20) : 0;
					end
				end
			endcase
		end
	end

	// monitor: predict on each accepted radicand, check each accepted root
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding   <= 0;
			sent_count    <= 0;
			checked_count <= 0;
		end else begin
			if (arg_if.valid && arg_if.ready) begin
				expected_roots.push_back(floor_sqrt(arg_if.radicand));
				sent_count <= sent_count + 1;
			end
			if (res_if.valid && res_if.ready) begin
				if (expected_roots.size() == 0) begin
					error_count++;
					$display("%0t: unexpected transaction, root %0d", $time, res_if.root);
				end else begin
					want_root = expected_roots.pop_front();
					if (res_if.root !== want_root) begin
						error_count++;
						$display("%0t: root mismatch, expected %0d, actual %0d",
							$time, want_root, res_if.root);
					end
				end
				checked_count <= checked_count + 1;
			end
			outstanding <= expected_roots.size();
		end
	end

	// watchdog: abort when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((arg_if.valid && arg_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		arg_if.valid    = 1'b0;
		arg_if.radicand = '0;
		res_if.ready    = 1'b0;
		idle_cycles     = 0;
		error_count     = 0;

		queue_radicand(32'h0000_0000, 1'b0);
		queue_radicand(32'h0000_0001, 1'b0);
		queue_radicand(32'h0000_0002, 1'b0);
		queue_radicand(32'h0000_0003, 1'b0);
		queue_radicand(32'h0000_0004, 1'b0);
		queue_radicand(32'h0000_0008, 1'b0);
		queue_radicand(32'h0000_0009, 1'b0);
		queue_radicand(32'h0000_00FF, 1'b0);
		queue_radicand(32'h0000_0100, 1'b0);
		queue_radicand(32'h0000_FFFF, 1'b0);
		queue_radicand(32'h0001_0000, 1'b0);
		queue_radicand(32'h3FFF_FFFF, 1'b0);
		queue_radicand(32'h4000_0000, 1'b0);
		queue_radicand(32'h7FFF_FFFF, 1'b0);
		queue_radicand(32'h8000_0000, 1'b0);
		queue_radicand(32'h5555_5555, 1'b0);
		queue_radicand(32'hAAAA_AAAA, 1'b0);
		queue_radicand(32'hFFFD_FFFF, 1'b0);
		queue_radicand(32'hFFFE_0000, 1'b0);
		queue_radicand(32'hFFFE_0001, 1'b0);
		queue_radicand(32'hFFFE_0002, 1'b0);
		queue_radicand(32'hFFFF_FFFE, 1'b0);
		queue_radicand(32'hFFFF_FFFF, 1'b0);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			queue_radicand(random_radicand(), (i % 400) == 0);
		total_items = pending_radicands.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (checked_count < total_items);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_roots.size() != 0) begin
			error_count += expected_roots.size();
			$display("%0t: %0d roots never arrived", $time, expected_roots.size());
		end
		$display("Summary: %0d radicands sent, %0d roots checked", sent_count, checked_count);
		$display("  edge values, perfect squares and neighbors, narrow and full-width random");
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[integer_square_root.f]
+incdir+rtl
rtl/isr_pkg.sv
rtl/isr_if.sv
rtl/isr_stage.sv
rtl/integer_square_root.sv
sim/tb_integer_square_root.sv
